@@ rtl/todclk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todclk_pkg
// Shared types, constants and display helpers for the time-of-day clock.
// ----------------------------------------------------------------------------
package todclk_pkg;

   localparam int unsigned TPS_W = 14;
   localparam logic [TPS_W-1:0] TPS_RESET = 14'd10000;

   localparam logic [5:0] SEC_WRAP  = 6'd60;
   localparam logic [5:0] MIN_WRAP  = 6'd60;
   localparam logic [4:0] HOUR_WRAP = 5'd24;

   localparam logic [7:0] LCD_SET_ADDR = 8'h80;
   localparam logic [7:0] ADDR_SEC     = 8'h06;
   localparam logic [7:0] ADDR_MIN     = 8'h03;
   localparam logic [7:0] ADDR_HOUR    = 8'h00;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_COLON  = 8'h3A;

   localparam int unsigned IDX_W = 5;

   typedef enum logic [1:0] {
      RUN_SEC  = 2'd0,
      RUN_MIN  = 2'd1,
      RUN_HOUR = 2'd2,
      RUN_DAY  = 2'd3
   } run_level_type;

   typedef struct packed {
      logic [2:0] tens;
      logic [3:0] ones;
   } digit_pair_type;

   typedef struct packed {
      run_level_type level;
      logic [2:0]    sec_tens;
      logic [3:0]    sec_ones;
      logic [2:0]    min_tens;
      logic [3:0]    min_ones;
      logic [1:0]    hour_tens;
      logic [3:0]    hour_ones;
   } run_desc_type;

   typedef struct packed {
      logic         push;
      run_desc_type desc;
   } queue_wr_type;

   typedef struct packed {
      logic         valid;
      run_desc_type desc;
   } queue_rd_type;

   typedef struct packed {
      logic [7:0] lcd_byte;
      logic       is_data;
   } lcd_entry_type;

   function automatic digit_pair_type to_digits(input logic [5:0] v);
      digit_pair_type d;
      logic [5:0]     tens_part;
      if (v >= 6'd60) begin
         d.tens = 3'd6;
      end else if (v >= 6'd50) begin
         d.tens = 3'd5;
      end else if (v >= 6'd40) begin
         d.tens = 3'd4;
      end else if (v >= 6'd30) begin
         d.tens = 3'd3;
      end else if (v >= 6'd20) begin
         d.tens = 3'd2;
      end else if (v >= 6'd10) begin
         d.tens = 3'd1;
      end else begin
         d.tens = 3'd0;
      end
      tens_part = {d.tens, 3'b000} + {2'b00, d.tens, 1'b0};
      d.ones = 4'(v - tens_part);
      return d;
   endfunction

   function automatic logic [IDX_W-1:0] last_index(input run_level_type level);
      logic [IDX_W-1:0] r;
      case (level)
         RUN_SEC:  r = 5'd2;
         RUN_MIN:  r = 5'd8;
         RUN_HOUR: r = 5'd17;
         RUN_DAY:  r = 5'd26;
         default:  r = 5'd2;
      endcase
      return r;
   endfunction

   function automatic lcd_entry_type byte_at(input logic [IDX_W-1:0] idx,
                                             input run_desc_type d);
      lcd_entry_type e;
      e.is_data  = 1'b1;
      e.lcd_byte = ASCII_ZERO;
      case (idx) inside
         5'd0: begin
            e.lcd_byte = LCD_SET_ADDR | ADDR_SEC;
            e.is_data  = 1'b0;
         end
         5'd3: begin
            e.lcd_byte = LCD_SET_ADDR | ADDR_MIN;
            e.is_data  = 1'b0;
         end
         5'd9, 5'd18: begin
            e.lcd_byte = LCD_SET_ADDR | ADDR_HOUR;
            e.is_data  = 1'b0;
         end
         5'd1:  e.lcd_byte = ASCII_ZERO | {5'b0, d.sec_tens};
         5'd2:  e.lcd_byte = ASCII_ZERO | {4'b0, d.sec_ones};
         5'd4:  e.lcd_byte = ASCII_ZERO | {5'b0, d.min_tens};
         5'd5:  e.lcd_byte = ASCII_ZERO | {4'b0, d.min_ones};
         5'd10: e.lcd_byte = ASCII_ZERO | {6'b0, d.hour_tens};
         5'd11: e.lcd_byte = ASCII_ZERO | {4'b0, d.hour_ones};
         5'd6, 5'd12, 5'd15, 5'd21, 5'd24: e.lcd_byte = ASCII_COLON;
         default: e.lcd_byte = ASCII_ZERO;
      endcase
      return e;
   endfunction

endpackage

@@ rtl/todclk_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todclk_if
// Valid/ready channel interfaces for the tick, display and register ports.
// ----------------------------------------------------------------------------
interface todclk_req_if;
   logic valid;
   logic ready;
   logic overflow_event;
   modport source (output valid, output overflow_event, input ready);
   modport sink   (input valid, input overflow_event, output ready);
endinterface

interface todclk_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] lcd_byte;
   logic       is_data;
   logic       last;
   modport source (output valid, output lcd_byte, output is_data, output last, input ready);
   modport sink   (input valid, input lcd_byte, input is_data, input last, output ready);
endinterface

interface todclk_csr_if;
   logic        valid;
   logic        ready;
   logic [13:0] ticks_per_second;
   modport source (output valid, output ticks_per_second, input ready);
   modport sink   (input valid, input ticks_per_second, output ready);
endinterface

@@ rtl/time_of_day_clock_lcd_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_clock_lcd_update
// HH:MM:SS clock driven by timer overflow items, emitting character-LCD bytes.
// ----------------------------------------------------------------------------
// The tick port takes one item every cycle while the run queue has room. Each
// second produces one run of 3, 9, 18 or 27 LCD bytes (set-address commands,
// ASCII digits and colons); the display sequencer sends one byte per cycle
// from its output register while the display port is ready. Up to QUEUE_DEPTH
// finished seconds wait between the counters and the sequencer; the tick port
// drops ready only while that queue is full. The ticks_per_second register
// resets to 10000 and is written through the csr port at any time.
module time_of_day_clock_lcd_update #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   todclk_req_if.sink   req_ch,
   todclk_rsp_if.source rsp_ch,
   todclk_csr_if.sink   csr_ch
);

   todclk_pkg::queue_wr_type queue_wr;
   todclk_pkg::queue_rd_type head;
   logic                     queue_full;
   logic                     pop;

   todclk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   todclk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   todclk_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last |-> rsp_ch.is_data)
      else $error("last byte of a run is not character data");

   a_cmd_has_addr_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.is_data |-> rsp_ch.lcd_byte[7])
      else $error("command byte without set-address flag");

   a_data_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_data |->
         (rsp_ch.lcd_byte >= todclk_pkg::ASCII_ZERO) &&
         (rsp_ch.lcd_byte <= todclk_pkg::ASCII_COLON))
      else $error("data byte is neither digit nor colon");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_wr.push |-> !queue_full)
      else $error("run pushed into a full queue");

endmodule

@@ rtl/todclk_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todclk_front
// Prescaler and time counters; classifies each second into a display run.
// ----------------------------------------------------------------------------
module todclk_front (
   input  logic                    clock,
   input  logic                    reset,
   todclk_req_if.sink              req_ch,
   todclk_csr_if.sink              csr_ch,
   input  logic                    queue_full,
   output todclk_pkg::queue_wr_type queue_wr
);

   logic [todclk_pkg::TPS_W-1:0] tps_ff, tps_in;
   logic [todclk_pkg::TPS_W-1:0] count_ff, count_in;
   logic [5:0] sec_ff, sec_in;
   logic [5:0] min_ff, min_in;
   logic [4:0] hour_ff, hour_in;

   logic [todclk_pkg::TPS_W:0] count_sum;
   logic       tick;
   logic       fire;
   logic [5:0] sec_inc;
   logic [5:0] min_inc;
   logic [4:0] hour_inc;
   logic       wrap_s;
   logic       wrap_m;
   logic       wrap_h;
   todclk_pkg::digit_pair_type sec_d, min_d, hour_d;

   assign req_ch.ready = !queue_full;
   assign csr_ch.ready = 1'b1;

   assign tick      = req_ch.valid && req_ch.ready && req_ch.overflow_event;
   assign count_sum = {1'b0, count_ff} + 15'd1;
   assign fire      = count_sum >= {1'b0, tps_ff};

   assign sec_inc  = sec_ff + 6'd1;
   assign min_inc  = min_ff + 6'd1;
   assign hour_inc = hour_ff + 5'd1;
   assign wrap_s   = sec_inc == todclk_pkg::SEC_WRAP;
   assign wrap_m   = wrap_s && (min_inc == todclk_pkg::MIN_WRAP);
   assign wrap_h   = wrap_m && (hour_inc == todclk_pkg::HOUR_WRAP);

   assign sec_d  = todclk_pkg::to_digits(sec_inc);
   assign min_d  = todclk_pkg::to_digits(min_inc);
   assign hour_d = todclk_pkg::to_digits({1'b0, hour_inc});

   always_comb begin
      tps_in   = csr_ch.valid ? csr_ch.ticks_per_second : tps_ff;
      count_in = count_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      if (tick) begin
         if (!fire) begin
            count_in = count_sum[todclk_pkg::TPS_W-1:0];
         end else begin
            count_in = '0;
            sec_in   = wrap_s ? 6'd0 : sec_inc;
            if (wrap_s) begin
               min_in = wrap_m ? 6'd0 : min_inc;
            end
            if (wrap_m) begin
               hour_in = wrap_h ? 5'd0 : hour_inc;
            end
         end
      end
   end

   always_comb begin
      queue_wr.push           = tick && fire;
      queue_wr.desc.sec_tens  = sec_d.tens;
      queue_wr.desc.sec_ones  = sec_d.ones;
      queue_wr.desc.min_tens  = min_d.tens;
      queue_wr.desc.min_ones  = min_d.ones;
      queue_wr.desc.hour_tens = hour_d.tens[1:0];
      queue_wr.desc.hour_ones = hour_d.ones;
      if (wrap_h) begin
         queue_wr.desc.level = todclk_pkg::RUN_DAY;
      end else if (wrap_m) begin
         queue_wr.desc.level = todclk_pkg::RUN_HOUR;
      end else if (wrap_s) begin
         queue_wr.desc.level = todclk_pkg::RUN_MIN;
      end else begin
         queue_wr.desc.level = todclk_pkg::RUN_SEC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff   <= todclk_pkg::TPS_RESET;
         count_ff <= '0;
         sec_ff   <= '0;
         min_ff   <= '0;
         hour_ff  <= '0;
      end else begin
         tps_ff   <= tps_in;
         count_ff <= count_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
      end
   end

endmodule

@@ rtl/todclk_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todclk_queue
// Short queue of display run descriptors between front and back.
// ----------------------------------------------------------------------------
module todclk_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  todclk_pkg::queue_wr_type queue_wr,
   input  logic                     pop,
   output logic                     full,
   output todclk_pkg::queue_rd_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   todclk_pkg::run_desc_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head.valid = count_ff != '0;
   assign head.desc  = mem[rd_ptr_ff];
   assign do_push    = queue_wr.push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= queue_wr.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/todclk_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todclk_back
// Display sequencer: expands each run descriptor into LCD bytes.
// ----------------------------------------------------------------------------
module todclk_back (
   input  logic                     clock,
   input  logic                     reset,
   input  todclk_pkg::queue_rd_type head,
   output logic                     pop,
   todclk_rsp_if.source             rsp_ch
);

   logic [todclk_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       is_data_ff, is_data_in;
   logic       last_ff, last_in;

   logic                      advance;
   logic                      is_last;
   todclk_pkg::lcd_entry_type entry;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign entry   = todclk_pkg::byte_at(idx_ff, head.desc);
   assign is_last = idx_ff == todclk_pkg::last_index(head.desc.level);
   assign pop     = advance && head.valid && is_last;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.lcd_byte = byte_ff;
   assign rsp_ch.is_data  = is_data_ff;
   assign rsp_ch.last     = last_ff;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      is_data_in   = is_data_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = head.valid;
         if (head.valid) begin
            byte_in    = entry.lcd_byte;
            is_data_in = entry.is_data;
            last_in    = is_last;
            idx_in     = is_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      is_data_ff <= is_data_in;
      last_ff    <= last_in;
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the time-of-day clock LCD update stream. Overflow
// items go in through the tick port and a scoreboard class predicts every LCD
// byte of each second's refresh run. The bench covers the reset rate, the
// smallest and largest rates, a rate lowered under the running count and a
// long unbroken stretch through two minute rollovers. Random segments then
// vary the rate, idle both sides and stall the display port long enough to
// fill the block.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned RUN_LIMIT   = 200_000;
   localparam int unsigned SETTLE      = 20;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned RANDOM_SEGS = 8;

   typedef struct packed {
      logic [7:0] lcd_byte;
      logic       is_data;
      logic       last;
   } lcd_item_type;

   class lcd_stream_board;
      logic [13:0]  rate;
      int unsigned  prescale;
      logic [5:0]   sec;
      logic [5:0]   mins;
      logic [4:0]   hrs;
      lcd_item_type pending_bytes[$];
      int           errors;
      int           day_wraps;

      function new();
         rate      = todclk_pkg::TPS_RESET;
         prescale  = 0;
         sec       = '0;
         mins      = '0;
         hrs       = '0;
         errors    = 0;
         day_wraps = 0;
      endfunction

      function void set_rate(input logic [13:0] v);
         rate = v;
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction

      function void push_byte(input logic [7:0] b, input logic d);
         lcd_item_type e;
         e.lcd_byte = b;
         e.is_data  = d;
         e.last     = 1'b0;
         pending_bytes.push_back(e);
      endfunction

      function void push_pair(input logic [5:0] v);
         push_byte(todclk_pkg::ASCII_ZERO + 8'(v / 10), 1'b1);
         push_byte(todclk_pkg::ASCII_ZERO + 8'(v % 10), 1'b1);
      endfunction

      function void count_tick(input logic ev);
         int unsigned nxt;
         int          i;
         if (!ev) return;
         nxt = prescale + 1;
         if (nxt < rate) begin
            prescale = nxt;
            return;
         end
         prescale = 0;

         sec = sec + 6'd1;
         push_byte(todclk_pkg::LCD_SET_ADDR | todclk_pkg::ADDR_SEC, 1'b0);
         push_pair(sec);
         if (sec == todclk_pkg::SEC_WRAP) begin
            sec  = '0;
            mins = mins + 6'd1;
            push_byte(todclk_pkg::LCD_SET_ADDR | todclk_pkg::ADDR_MIN, 1'b0);
            push_pair(mins);
            push_byte(todclk_pkg::ASCII_COLON, 1'b1);
            push_pair(sec);
         end
         if (mins == todclk_pkg::MIN_WRAP) begin
            mins = '0;
            hrs  = hrs + 5'd1;
            push_byte(todclk_pkg::LCD_SET_ADDR | todclk_pkg::ADDR_HOUR, 1'b0);
            push_pair(6'(hrs));
            push_byte(todclk_pkg::ASCII_COLON, 1'b1);
            push_pair(mins);
            push_byte(todclk_pkg::ASCII_COLON, 1'b1);
            push_pair(sec);
         end
         if (hrs == todclk_pkg::HOUR_WRAP) begin
            hrs = '0;
            day_wraps++;
            push_byte(todclk_pkg::LCD_SET_ADDR | todclk_pkg::ADDR_HOUR, 1'b0);
            for (i = 0; i < 8; i++) begin
               push_byte((i == 2 || i == 5) ? todclk_pkg::ASCII_COLON
                                            : todclk_pkg::ASCII_ZERO, 1'b1);
            end
         end
         pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      endfunction

      task flag_mismatch(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_lcd_byte(input logic [7:0] b, input logic d, input logic l);
         lcd_item_type want;
         if (pending_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected item lcd_byte=%02h", b));
            return;
         end
         want = pending_bytes.pop_front();
         if (b !== want.lcd_byte)
            flag_mismatch($sformatf("lcd_byte %02h, want %02h", b, want.lcd_byte));
         if (d !== want.is_data)
            flag_mismatch($sformatf("is_data %b, want %b", d, want.is_data));
         if (l !== want.last)
            flag_mismatch($sformatf("last %b, want %b", l, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   todclk_req_if req_ch();
   todclk_rsp_if rsp_ch();
   todclk_csr_if csr_ch();

   time_of_day_clock_lcd_update uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   lcd_stream_board board = new();
   bit tx_idle  = 1'b1;
   bit rx_idle  = 1'b1;
   int hold_len = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.overflow_event  = 1'b0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.ticks_per_second = '0;
   end

   task automatic send_tick(input logic ev);
      while (tx_idle && $urandom_range(99) < 38) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.overflow_event <= ev;
      do @(posedge clock); while (!req_ch.ready);
      board.count_tick(ev);
   endtask

   task automatic drain_results;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_rate(input logic [13:0] v);
      req_ch.valid <= 1'b0;
      drain_results();
      csr_ch.valid            <= 1'b1;
      csr_ch.ticks_per_second <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      board.set_rate(v);
   endtask

   // display port: check items, idle at random, honor hold-off requests
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_lcd_byte(rsp_ch.lcd_byte, rsp_ch.is_data, rsp_ch.last);
         if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= !(rx_idle && $urandom_range(99) < 38);
         end
      end
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int          n;
      int          seg;
      logic [13:0] next_rate;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset rate
      for (n = 0; n < 20; n++) send_tick($urandom_range(9) != 0);

      write_rate(14'd1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);

      write_rate(14'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // lower the rate under the running count
      write_rate(14'd3);
      send_tick(1'b1);
      send_tick(1'b1);
      write_rate(14'd2);
      send_tick(1'b1);
      write_rate(14'd6);
      repeat (5) send_tick(1'b1);
      write_rate(14'd1);
      send_tick(1'b1);

      // largest rate, then lowered under the count
      write_rate(14'h3FFF);
      repeat (12) send_tick(1'b1);
      write_rate(14'd7);
      send_tick(1'b1);

      // long stretch with no idling, through two minute rollovers
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      write_rate(14'd1);
      repeat (130) send_tick(1'b1);
      tx_idle = 1'b1;
      rx_idle = 1'b1;

      for (seg = 0; seg < RANDOM_SEGS; seg++) begin
         case ($urandom_range(9))
            0:       next_rate = 14'd0;
            8, 9:    next_rate = 14'($urandom_range(5, 12));
            default: next_rate = 14'($urandom_range(1, 4));
         endcase
         if (seg == 4) next_rate = 14'd1;
         write_rate(next_rate);
         if (seg == 4) begin
            hold_len = HOLD_CYCLES;
            tx_idle  = 1'b0;
         end
         if (seg == 7) begin
            tx_idle = 1'b0;
            rx_idle = 1'b0;
         end
         repeat ($urandom_range(30, 55)) send_tick($urandom_range(99) < 80);
         tx_idle = 1'b1;
         rx_idle = 1'b1;
      end

      req_ch.valid <= 1'b0;
      drain_results();
      repeat (50) @(posedge clock);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

@@ time_of_day_clock_lcd_update.f @@
rtl/todclk_pkg.sv
rtl/todclk_if.sv
rtl/todclk_front.sv
rtl/todclk_queue.sv
rtl/todclk_back.sv
rtl/time_of_day_clock_lcd_update.sv
test/tb_top.sv
